[hw/rtl/sgd_pkg.sv]
package sgd_pkg;

   // image geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // configuration register fields
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

   // commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // datapath widths
   localparam int PIX_W  = 8;
   localparam int GRAD_W = 11;
   localparam int ABS_W  = 10;
   localparam int SQ_W   = 2 * ABS_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int PROD_W = 22;
   localparam int ROOT_W = 12;
   localparam int STEP_W = $clog2(ROOT_W);
   localparam int MAG_W  = 8;
   localparam int DIR_W  = 2;

   localparam int MAG_MAX   = 255;
   localparam int TAN_LO    = 414;
   localparam int TAN_HI    = 2414;
   localparam int TAN_SCALE = 1000;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_0   = DIR_W'(0);
   localparam logic [DIR_W-1:0] DIR_45  = DIR_W'(1);
   localparam logic [DIR_W-1:0] DIR_90  = DIR_W'(2);
   localparam logic [DIR_W-1:0] DIR_135 = DIR_W'(3);

   typedef struct packed {
      logic             command;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [DIR_W-1:0] direction;
      logic             frame_end;
   } rsp_type;

   // window[row][col], row 0 is the oldest line
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic start;
      logic update;
      logic restart;
   } win_cmd_type;

   typedef struct packed {
      logic tail_pending;
      logic emit;
   } win_status_type;

   typedef struct packed {
      logic start;
      logic border;
      logic frame_end;
   } grad_cmd_type;

endpackage

[hw/rtl/sgd_ram.sv]
module sgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sgd_window.sv]
module sgd_window (
   input  logic                           clock,
   input  logic                           reset,
   input  sgd_pkg::win_cmd_type           cmd,
   input  logic [sgd_pkg::PIX_W-1:0]      pixel,
   input  logic [sgd_pkg::WIDTH_W-1:0]    width,
   input  logic [sgd_pkg::HEIGHT_W-1:0]   height,
   output sgd_pkg::win_status_type        status,
   output sgd_pkg::win_type               window
);

   logic [sgd_pkg::COL_W-1:0]   col_ff, col_in;
   logic [sgd_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                        tail_ff, tail_in;
   logic [sgd_pkg::COL_W:0]     fill_ff, fill_in;
   logic [sgd_pkg::PIX_W-1:0]   pix_ff;
   sgd_pkg::win_type            win_ff, win_in;

   logic [2*sgd_pkg::PIX_W-1:0] rd_data;
   logic [2*sgd_pkg::PIX_W-1:0] wr_data;
   logic                        entry_written;
   logic [sgd_pkg::PIX_W-1:0]   older_pix;
   logic [sgd_pkg::PIX_W-1:0]   newer_pix;
   logic [sgd_pkg::WIDTH_W-1:0] col_next;
   logic [sgd_pkg::HEIGHT_W-1:0] row_next;

   // both line stores share one entry: older line high, newer line low
   sgd_ram #(
      .WIDTH (2 * sgd_pkg::PIX_W),
      .DEPTH (sgd_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (col_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.start),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   // columns at or above the fill count were never written and read as zero
   assign entry_written = {1'b0, col_ff} < fill_ff;
   assign older_pix     = entry_written ? rd_data[2*sgd_pkg::PIX_W-1:sgd_pkg::PIX_W] : '0;
   assign newer_pix     = entry_written ? rd_data[sgd_pkg::PIX_W-1:0] : '0;
   assign wr_data       = {newer_pix, pix_ff};

   assign col_next = sgd_pkg::WIDTH_W'(col_ff) + sgd_pkg::WIDTH_W'(1);
   assign row_next = sgd_pkg::HEIGHT_W'(row_ff) + sgd_pkg::HEIGHT_W'(1);

   // raster counters, window shift and fill tracking
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      win_in  = win_ff;
      if (cmd.update) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = older_pix;
         win_in[1][2] = newer_pix;
         win_in[2][2] = pix_ff;
         if ({1'b0, col_ff} == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      priority if (cmd.restart) begin
         col_in  = '0;
         row_in  = '0;
         tail_in = 1'b0;
      end else if (cmd.update) begin
         col_in = col_ff + 1'b1;
         if (col_next >= width) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
            if (row_next >= height) begin
               row_in  = '0;
               tail_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         tail_ff <= 1'b0;
         fill_ff <= '0;
         win_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         win_ff  <= win_in;
      end
   end

   // pixel held while the line entry is read
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pix_ff <= pixel;
      end
   end

   assign status.tail_pending = tail_ff;
   assign status.emit = (row_ff >= sgd_pkg::ROW_W'(2)) ||
                        (row_ff == sgd_pkg::ROW_W'(1) && col_ff != '0);
   assign window = win_ff;

   // tail wait only starts from a wrapped raster position
   assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> (col_ff == '0 && row_ff == '0))
      else $error("tail pending with nonzero input counters");

   // write back only follows the read of the same transaction
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.start))
      else $error("line store write without preceding read");

endmodule

[hw/rtl/sgd_grad.sv]
module sgd_grad (
   input  logic                   clock,
   input  logic                   reset,
   input  sgd_pkg::grad_cmd_type  cmd,
   input  logic                   take,
   input  sgd_pkg::win_type       window,
   output logic                   done,
   output sgd_pkg::rsp_type       result
);

   localparam logic [2:0] G_IDLE   = 3'd0;
   localparam logic [2:0] G_SQUARE = 3'd1;
   localparam logic [2:0] G_SUM    = 3'd2;
   localparam logic [2:0] G_ROOT   = 3'd3;
   localparam logic [2:0] G_DONE   = 3'd4;

   logic [2:0]                   gstate_ff, gstate_in;
   logic [sgd_pkg::GRAD_W-1:0]   gx_ff, gy_ff;
   logic                         border_ff, fe_ff;
   logic [sgd_pkg::SQ_W-1:0]     sqx_ff, sqy_ff;
   logic [sgd_pkg::PROD_W-1:0]   p_ay_ff, p_lo_ff, p_hi_ff;
   logic [sgd_pkg::SUM_W-1:0]    sum_ff;
   logic [sgd_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [sgd_pkg::STEP_W-1:0]   step_ff, step_in;

   logic [sgd_pkg::GRAD_W-1:0]   pos_x, neg_x, pos_y, neg_y;
   logic [sgd_pkg::GRAD_W-1:0]   abs_x_full, abs_y_full;
   logic [sgd_pkg::ABS_W-1:0]    abs_x, abs_y;
   logic [sgd_pkg::ROOT_W-1:0]   trial;
   logic [2*sgd_pkg::ROOT_W-1:0] trial_sq;
   logic                         same_sign;
   logic [sgd_pkg::DIR_W-1:0]    dir;

   // sobel sums from the window
   assign pos_x = sgd_pkg::GRAD_W'(window[0][2]) + (sgd_pkg::GRAD_W'(window[1][2]) << 1) +
                  sgd_pkg::GRAD_W'(window[2][2]);
   assign neg_x = sgd_pkg::GRAD_W'(window[0][0]) + (sgd_pkg::GRAD_W'(window[1][0]) << 1) +
                  sgd_pkg::GRAD_W'(window[2][0]);
   assign pos_y = sgd_pkg::GRAD_W'(window[2][0]) + (sgd_pkg::GRAD_W'(window[2][1]) << 1) +
                  sgd_pkg::GRAD_W'(window[2][2]);
   assign neg_y = sgd_pkg::GRAD_W'(window[0][0]) + (sgd_pkg::GRAD_W'(window[0][1]) << 1) +
                  sgd_pkg::GRAD_W'(window[0][2]);

   // absolute gradients, always below 1024
   assign abs_x_full = gx_ff[sgd_pkg::GRAD_W-1] ? (~gx_ff + 1'b1) : gx_ff;
   assign abs_y_full = gy_ff[sgd_pkg::GRAD_W-1] ? (~gy_ff + 1'b1) : gy_ff;
   assign abs_x      = abs_x_full[sgd_pkg::ABS_W-1:0];
   assign abs_y      = abs_y_full[sgd_pkg::ABS_W-1:0];

   // one root bit per cycle
   assign trial    = root_ff | (sgd_pkg::ROOT_W'(1) << step_ff);
   assign trial_sq = trial * trial;

   always_comb begin
      gstate_in = gstate_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      unique case (gstate_ff)
         G_IDLE: begin
            if (cmd.start) begin
               gstate_in = G_SQUARE;
            end
         end
         G_SQUARE: begin
            gstate_in = G_SUM;
         end
         G_SUM: begin
            root_in   = '0;
            step_in   = sgd_pkg::STEP_W'(sgd_pkg::ROOT_W - 1);
            gstate_in = G_ROOT;
         end
         G_ROOT: begin
            if (trial_sq <= (2 * sgd_pkg::ROOT_W)'(sum_ff)) begin
               root_in = trial;
            end
            if (step_ff == '0) begin
               gstate_in = G_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         G_DONE: begin
            if (take) begin
               gstate_in = G_IDLE;
            end
         end
         default: begin
            gstate_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gstate_ff <= G_IDLE;
      end else begin
         gstate_ff <= gstate_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      root_ff <= root_in;
      step_ff <= step_in;
      if (gstate_ff == G_IDLE && cmd.start) begin
         gx_ff     <= pos_x - neg_x;
         gy_ff     <= pos_y - neg_y;
         border_ff <= cmd.border;
         fe_ff     <= cmd.frame_end;
      end
      if (gstate_ff == G_SQUARE) begin
         sqx_ff  <= abs_x * abs_x;
         sqy_ff  <= abs_y * abs_y;
         p_ay_ff <= sgd_pkg::PROD_W'(abs_y) * sgd_pkg::PROD_W'(sgd_pkg::TAN_SCALE);
         p_lo_ff <= sgd_pkg::PROD_W'(abs_x) * sgd_pkg::PROD_W'(sgd_pkg::TAN_LO);
         p_hi_ff <= sgd_pkg::PROD_W'(abs_x) * sgd_pkg::PROD_W'(sgd_pkg::TAN_HI);
      end
      if (gstate_ff == G_SUM) begin
         sum_ff <= sgd_pkg::SUM_W'(sqx_ff) + sgd_pkg::SUM_W'(sqy_ff);
      end
   end

   // quantized direction from ratio tests
   assign same_sign = gx_ff[sgd_pkg::GRAD_W-1] == gy_ff[sgd_pkg::GRAD_W-1];

   always_comb begin
      priority if (p_ay_ff <= p_lo_ff) begin
         dir = sgd_pkg::DIR_0;
      end else if (p_ay_ff >= p_hi_ff) begin
         dir = sgd_pkg::DIR_90;
      end else if (same_sign) begin
         dir = sgd_pkg::DIR_45;
      end else begin
         dir = sgd_pkg::DIR_135;
      end
   end

   assign done = gstate_ff == G_DONE;

   always_comb begin
      result.frame_end = fe_ff;
      if (border_ff) begin
         result.magnitude = '0;
         result.direction = sgd_pkg::DIR_0;
      end else begin
         result.magnitude = (root_ff > sgd_pkg::ROOT_W'(sgd_pkg::MAG_MAX)) ?
                            sgd_pkg::MAG_W'(sgd_pkg::MAG_MAX) : root_ff[sgd_pkg::MAG_W-1:0];
         result.direction = dir;
      end
   end

endmodule

[hw/rtl/sobel_gradient_direction.sv]
// 3x3 sobel edge detector with quantized gradient direction.
// req channel: one transaction per pixel (command pixel) or per tail result
// (command drain), in raster order. rsp channel: magnitude, direction and a
// frame_end flag on the frame's last result. csr channel: frame_width (index
// 0) and frame_height (index 1), always ready; writing either restarts the frame.
// A pixel produces the result of the pixel width+1 positions behind it once
// that pixel's neighborhood is in; after the last pixel of a frame further
// pixels are dropped and each drain transaction gives one tail result.
// Steps per transaction: a pixel without a result does a line store read, then
// write back and window shift; a pixel with a result adds the square and sum
// stages and the bit-serial square root of 12 iterations, which a drain runs
// alone. One transaction is in flight at a time, and req is stalled from
// acceptance until that transaction is done.
// A result shows on rsp from an output register: a stalled receiver holds it
// there while the next transaction is taken. A later result that finds the
// register still full waits in the gradient unit and keeps req stalled.
// Reset clears counters, window and line store fill count (unwritten line
// entries read as zero, no clearing pass) and sets 640x480.
module sobel_gradient_direction (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sgd_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sgd_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sgd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sgd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WIN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_GRAD = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [sgd_pkg::WIDTH_W-1:0]    width_ff, width_in;
   logic [sgd_pkg::HEIGHT_W-1:0]   height_ff, height_in;
   logic [sgd_pkg::COL_W-1:0]      out_col_ff, out_col_in;
   logic [sgd_pkg::ROW_W-1:0]      out_row_ff, out_row_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sgd_pkg::rsp_type               rsp_data_ff;

   logic                           accept;
   logic                           cfg_write;
   logic                           cfg_hit;
   logic                           out_free;
   logic                           take;
   logic                           border;
   logic                           last_pos;
   logic [sgd_pkg::WIDTH_W-1:0]    w_last;
   logic [sgd_pkg::HEIGHT_W-1:0]   h_last;
   logic [sgd_pkg::WIDTH_W-1:0]    wr_width;
   logic [sgd_pkg::HEIGHT_W-1:0]   wr_height;

   sgd_pkg::win_cmd_type           win_cmd;
   sgd_pkg::win_status_type        win_status;
   sgd_pkg::win_type               window;
   sgd_pkg::grad_cmd_type          grad_cmd;
   logic                           grad_done;
   sgd_pkg::rsp_type               grad_result;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign cfg_hit   = cfg_write && (csr_index == sgd_pkg::REG_FRAME_WIDTH ||
                                    csr_index == sgd_pkg::REG_FRAME_HEIGHT);

   // size registers hold the clamped values in use
   assign wr_width  = csr_wdata[sgd_pkg::WIDTH_W-1:0];
   assign wr_height = csr_wdata[sgd_pkg::HEIGHT_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write && csr_index == sgd_pkg::REG_FRAME_WIDTH) begin
         priority if (wr_width < sgd_pkg::WIDTH_MIN) begin
            width_in = sgd_pkg::WIDTH_MIN;
         end else if (wr_width > sgd_pkg::WIDTH_MAX) begin
            width_in = sgd_pkg::WIDTH_MAX;
         end else begin
            width_in = wr_width;
         end
      end
      if (cfg_write && csr_index == sgd_pkg::REG_FRAME_HEIGHT) begin
         priority if (wr_height < sgd_pkg::HEIGHT_MIN) begin
            height_in = sgd_pkg::HEIGHT_MIN;
         end else if (wr_height > sgd_pkg::HEIGHT_MAX) begin
            height_in = sgd_pkg::HEIGHT_MAX;
         end else begin
            height_in = wr_height;
         end
      end
   end

   // border and frame end at the output position
   assign w_last   = width_ff - 1'b1;
   assign h_last   = height_ff - 1'b1;
   assign last_pos = sgd_pkg::HEIGHT_W'(out_row_ff) >= h_last &&
                     sgd_pkg::WIDTH_W'(out_col_ff) >= w_last;
   assign border   = out_row_ff == '0 || out_col_ff == '0 ||
                     sgd_pkg::HEIGHT_W'(out_row_ff) >= h_last ||
                     sgd_pkg::WIDTH_W'(out_col_ff) >= w_last;

   // window unit control
   assign win_cmd.start   = accept && req_payload.command == sgd_pkg::CMD_PIXEL &&
                            !win_status.tail_pending;
   assign win_cmd.update  = state_ff == ST_WIN;
   assign win_cmd.restart = cfg_hit || (state_ff == ST_EMIT && last_pos);

   // gradient unit control
   assign grad_cmd.start     = state_ff == ST_EMIT;
   assign grad_cmd.border    = border;
   assign grad_cmd.frame_end = last_pos;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = state_ff == ST_GRAD && grad_done && out_free;

   sgd_window u_window (
      .clock  (clock),
      .reset  (reset),
      .cmd    (win_cmd),
      .pixel  (req_payload.pixel),
      .width  (width_ff),
      .height (height_ff),
      .status (win_status),
      .window (window)
   );

   sgd_grad u_grad (
      .clock  (clock),
      .reset  (reset),
      .cmd    (grad_cmd),
      .take   (take),
      .window (window),
      .done   (grad_done),
      .result (grad_result)
   );

   // transaction sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (win_cmd.start) begin
                  state_in = ST_WIN;
               end else if (req_payload.command == sgd_pkg::CMD_DRAIN &&
                            win_status.tail_pending) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WIN: begin
            state_in = win_status.emit ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output position counters
   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      priority if (cfg_hit || (state_ff == ST_EMIT && last_pos)) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (state_ff == ST_EMIT) begin
         if (sgd_pkg::WIDTH_W'(out_col_ff) + sgd_pkg::WIDTH_W'(1) >= width_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= sgd_pkg::WIDTH_RESET;
         height_ff    <= sgd_pkg::HEIGHT_RESET;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= grad_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // gradient unit only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      grad_done |-> state_ff == ST_GRAD)
      else $error("gradient result outside of wait state");

   // output column stays inside the row
   assert property (@(posedge clock) disable iff (reset)
      sgd_pkg::WIDTH_W'(out_col_ff) < width_ff)
      else $error("output column beyond frame width");

   // frame end result leaves the block restarted
   assert property (@(posedge clock) disable iff (reset)
      (take && grad_result.frame_end) |=>
         (out_row_ff == '0 && out_col_ff == '0 && !win_status.tail_pending))
      else $error("frame end without counter restart");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 600;
   localparam int MAX_REPORTS   = 200;

   // indexes outside the register map, written to show they change nothing
   localparam logic [sgd_pkg::CSR_INDEX_W-1:0] REG_SPARE_2 = sgd_pkg::CSR_INDEX_W'(2);
   localparam logic [sgd_pkg::CSR_INDEX_W-1:0] REG_SPARE_3 = sgd_pkg::CSR_INDEX_W'(3);

   // 5x3 frame: a bright block over a dark bottom row, giving saturated
   // interior results at 0, 135 and 90 degrees
   localparam logic [sgd_pkg::PIX_W-1:0] EDGE_FRAME [15] = '{
      8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
      8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
      8'd0, 8'd0, 8'd0,   8'd0,   8'd0
   };

   typedef enum int {TEX_NOISE, TEX_GRAIN, TEX_FLAT, TEX_RAMP} texture_type;

   typedef struct packed {
      logic             hold;
      sgd_pkg::req_type req;
   } stim_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   sgd_pkg::req_type                req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   sgd_pkg::rsp_type                rsp_payload;
   logic                            csr_valid   = 1'b0;
   logic                            csr_ready;
   logic [sgd_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [sgd_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   // stimulus and expectations
   stim_type         pixel_queue[$];
   sgd_pkg::rsp_type pending_gradients[$];
   logic             req_busy = 1'b0;
   int               send_gap = 0;
   int               stall_left = 0;
   int               fault_count = 0;
   int               accepted_count = 0;
   int               result_count = 0;
   int               frame_count = 0;
   int               csr_writes = 0;
   int               live_items = 0;
   logic [31:0]      tick = '0;
   logic             quiet;

   // shadow of the block's registers and image state
   logic [sgd_pkg::WIDTH_W-1:0]  cfg_width  = sgd_pkg::WIDTH_RESET;
   logic [sgd_pkg::HEIGHT_W-1:0] cfg_height = sgd_pkg::HEIGHT_RESET;
   logic [sgd_pkg::PIX_W-1:0]    line_older [sgd_pkg::MAX_WIDTH];
   logic [sgd_pkg::PIX_W-1:0]    line_newer [sgd_pkg::MAX_WIDTH];
   sgd_pkg::win_type             pix_window = '0;
   logic [sgd_pkg::ROW_W-1:0]    in_row  = '0;
   logic [sgd_pkg::COL_W-1:0]    in_col  = '0;
   logic [sgd_pkg::ROW_W-1:0]    out_row = '0;
   logic [sgd_pkg::COL_W-1:0]    out_col = '0;
   logic                         tail_pending = 1'b0;

   sobel_gradient_direction dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // recurring stretches with no idling on either side
   always @(posedge clock) begin
      tick <= tick + 32'd1;
   end
   assign quiet = tick[11:10] == 2'b11;

   function automatic int pick_gap();
      int roll;
      if (quiet) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_int(input int value, input int lo, input int hi);
      if (value < lo) begin
         return lo;
      end
      if (value > hi) begin
         return hi;
      end
      return value;
   endfunction

   function automatic int frame_cols();
      return clamp_int(int'(cfg_width), sgd_pkg::WIDTH_MIN, sgd_pkg::WIDTH_MAX);
   endfunction

   function automatic int frame_rows();
      return clamp_int(int'(cfg_height), sgd_pkg::HEIGHT_MIN, sgd_pkg::HEIGHT_MAX);
   endfunction

   task automatic restart_frame();
      in_row       = '0;
      in_col       = '0;
      out_row      = '0;
      out_col      = '0;
      tail_pending = 1'b0;
   endtask

   // gradient result at the output position, then advance that position
   task automatic emit_gradient();
      int               w, h, gx, gy, ax, ay, sq, root, trial, b;
      sgd_pkg::rsp_type grad;
      w    = frame_cols();
      h    = frame_rows();
      grad = '0;
      if (out_row != 0 && int'(out_row) < h - 1 && out_col != 0 && int'(out_col) < w - 1) begin
         gx = (int'(pix_window[0][2]) - int'(pix_window[0][0]))
            + 2 * (int'(pix_window[1][2]) - int'(pix_window[1][0]))
            + (int'(pix_window[2][2]) - int'(pix_window[2][0]));
         gy = (int'(pix_window[2][0]) + 2 * int'(pix_window[2][1]) + int'(pix_window[2][2]))
            - (int'(pix_window[0][0]) + 2 * int'(pix_window[0][1]) + int'(pix_window[0][2]));
         // bit-by-bit floor square root
         sq   = gx * gx + gy * gy;
         root = 0;
         for (b = sgd_pkg::ROOT_W - 1; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sq) begin
               root = trial;
            end
         end
         grad.magnitude = root > sgd_pkg::MAG_MAX ? sgd_pkg::MAG_W'(sgd_pkg::MAG_MAX) :
                                                    sgd_pkg::MAG_W'(root);
         // quantize by tan(22.5) and tan(67.5) ratio tests
         ax = gx < 0 ? -gx : gx;
         ay = gy < 0 ? -gy : gy;
         if (ax == 0 && ay == 0) begin
            grad.direction = sgd_pkg::DIR_0;
         end else if (ay * sgd_pkg::TAN_SCALE <= ax * sgd_pkg::TAN_LO) begin
            grad.direction = sgd_pkg::DIR_0;
         end else if (ay * sgd_pkg::TAN_SCALE >= ax * sgd_pkg::TAN_HI) begin
            grad.direction = sgd_pkg::DIR_90;
         end else if ((gx >= 0) == (gy >= 0)) begin
            grad.direction = sgd_pkg::DIR_45;
         end else begin
            grad.direction = sgd_pkg::DIR_135;
         end
      end
      grad.frame_end = int'(out_row) >= h - 1 && int'(out_col) >= w - 1;
      pending_gradients.push_back(grad);
      if (grad.frame_end) begin
         restart_frame();
      end else if (int'(out_col) + 1 >= w) begin
         out_col = '0;
         out_row = out_row + 1'b1;
      end else begin
         out_col = out_col + 1'b1;
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         fault_count++;
         // keep the log readable once things go wrong
         if (fault_count <= MAX_REPORTS) begin
            $error("%s: expected %0d, got %0d", field, want, got);
         end
      end
   endtask

   // request driver, with the image state updated on each accepted transaction
   always @(posedge clock) begin : req_driver
      stim_type                  next_item;
      logic                      next_valid;
      sgd_pkg::req_type          next_req;
      logic [sgd_pkg::PIX_W-1:0] above2, above1;
      logic                      emit_now;
      int                        w, h, r;
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         send_gap    = 0;
         req_busy    = 1'b0;
      end else begin
         next_valid = req_valid;
         next_req   = req_payload;
         if (req_valid && !req_stall) begin
            accepted_count++;
            next_valid = 1'b0;
            w = frame_cols();
            h = frame_rows();
            if (req_payload.command == sgd_pkg::CMD_DRAIN) begin
               // drains only count once the frame's last pixel is in
               if (tail_pending) begin
                  emit_gradient();
               end
            end else if (!tail_pending) begin
               above2   = line_older[in_col];
               above1   = line_newer[in_col];
               emit_now = in_row >= 2 || (in_row == 1 && in_col >= 1);
               line_older[in_col] = above1;
               line_newer[in_col] = req_payload.pixel;
               for (r = 0; r < 3; r++) begin
                  pix_window[r][0] = pix_window[r][1];
                  pix_window[r][1] = pix_window[r][2];
               end
               pix_window[0][2] = above2;
               pix_window[1][2] = above1;
               pix_window[2][2] = req_payload.pixel;
               if (int'(in_col) + 1 >= w) begin
                  in_col = '0;
                  if (int'(in_row) + 1 >= h) begin
                     in_row       = '0;
                     tail_pending = 1'b1;
                  end else begin
                     in_row = in_row + 1'b1;
                  end
               end else begin
                  in_col = in_col + 1'b1;
               end
               if (emit_now) begin
                  emit_gradient();
               end
            end
         end
         // next transaction after the gap and, on a hold, once results have drained
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (pixel_queue.size() != 0 &&
                         !(pixel_queue[0].hold && pending_gradients.size() != 0)) begin
               next_item  = pixel_queue.pop_front();
               next_req   = next_item.req;
               next_valid = 1'b1;
               send_gap   = pick_gap();
            end
         end
         req_busy = next_valid;
         req_valid   <= next_valid;
         req_payload <= next_req;
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : rsp_monitor
      sgd_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (pending_gradients.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $error("unexpected result: magnitude %0d direction %0d frame_end %0d",
                         rsp_payload.magnitude, rsp_payload.direction, rsp_payload.frame_end);
               end
            end else begin
               want = pending_gradients.pop_front();
               check_field("magnitude", want.magnitude, rsp_payload.magnitude);
               check_field("direction", want.direction, rsp_payload.direction);
               check_field("frame_end", want.frame_end, rsp_payload.frame_end);
               if (want.frame_end) begin
                  frame_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left = stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   task automatic push_item(input logic hold, input logic command,
                            input logic [sgd_pkg::PIX_W-1:0] value);
      stim_type item;
      item.hold        = hold;
      item.req.command = command;
      item.req.pixel   = value;
      pixel_queue.push_back(item);
   endtask

   // wait until everything sent has come back and the block has gone quiet
   task automatic settle_block();
      while (pixel_queue.size() != 0 || req_busy || pending_gradients.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [sgd_pkg::CSR_INDEX_W-1:0] index,
                                 input int value);
      logic [sgd_pkg::CSR_DATA_W-1:0] data;
      data = sgd_pkg::CSR_DATA_W'(value);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      if (index == sgd_pkg::REG_FRAME_WIDTH) begin
         cfg_width = data[sgd_pkg::WIDTH_W-1:0];
         restart_frame();
      end else if (index == sgd_pkg::REG_FRAME_HEIGHT) begin
         cfg_height = data[sgd_pkg::HEIGHT_W-1:0];
         restart_frame();
      end
   endtask

   // raster frame of the given texture; a full frame is followed by its tail
   // drains, with occasional ignored drains and pixels mixed in
   task automatic queue_frame(input int w, input int h, input texture_type texture,
                              input logic hold_first, input int pixel_total);
      int base, slope_x, slope_y, n, value;
      base    = $urandom_range(0, 255);
      slope_x = $urandom_range(0, 12) - 6;
      slope_y = $urandom_range(0, 12) - 6;
      for (n = 0; n < pixel_total; n++) begin
         if ($urandom_range(0, 49) == 0) begin
            push_item(1'b0, sgd_pkg::CMD_DRAIN, sgd_pkg::PIX_W'($urandom));
         end
         case (texture)
            TEX_NOISE: value = $urandom_range(0, 255);
            TEX_GRAIN: value = base + $urandom_range(0, 7);
            TEX_FLAT:  value = base;
            default:   value = base + slope_x * (n % w) + slope_y * (n / w);
         endcase
         push_item(hold_first && n == 0, sgd_pkg::CMD_PIXEL,
                   sgd_pkg::PIX_W'(clamp_int(value, 0, 255)));
         live_items++;
      end
      if (pixel_total == w * h) begin
         if ($urandom_range(0, 3) == 0) begin
            push_item(1'b0, sgd_pkg::CMD_PIXEL, sgd_pkg::PIX_W'($urandom));
         end
         repeat (w + 1) begin
            push_item(1'b0, sgd_pkg::CMD_DRAIN, sgd_pkg::PIX_W'($urandom));
            live_items++;
         end
         if ($urandom_range(0, 3) == 0) begin
            push_item(1'b0, sgd_pkg::CMD_DRAIN, sgd_pkg::PIX_W'($urandom));
         end
      end
   endtask

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int w_val, h_val, frames, area, roll, n;
      foreach (line_older[i]) begin
         line_older[i] = '0;
         line_newer[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: small frame with black and white edges, drain before the
      // tail, pixel during the tail, drain after the frame end, and a hold
      // until all results are back before the tail drains
      write_register(sgd_pkg::REG_FRAME_WIDTH, 5);
      write_register(sgd_pkg::REG_FRAME_HEIGHT, 3);
      push_item(1'b0, sgd_pkg::CMD_DRAIN, 8'hFF);
      for (n = 0; n < 15; n++) begin
         push_item(1'b0, sgd_pkg::CMD_PIXEL, EDGE_FRAME[n]);
      end
      push_item(1'b0, sgd_pkg::CMD_PIXEL, 8'hA5);
      push_item(1'b1, sgd_pkg::CMD_DRAIN, 8'h00);
      repeat (5) push_item(1'b0, sgd_pkg::CMD_DRAIN, 8'h5A);
      push_item(1'b0, sgd_pkg::CMD_DRAIN, 8'hFF);
      write_register(REG_SPARE_2, $urandom_range(0, 8191));
      write_register(REG_SPARE_3, $urandom_range(0, 8191));

      // random frames of small sizes, some written out of range
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            w_val = $urandom_range(0, 2);
         end else if (roll < 4) begin
            w_val = $urandom_range(11, 32);
         end else begin
            w_val = $urandom_range(3, 10);
         end
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            h_val = $urandom_range(0, 2);
         end else if (roll < 3) begin
            h_val = $urandom_range(6, 12);
         end else begin
            h_val = $urandom_range(3, 5);
         end
         write_register(sgd_pkg::REG_FRAME_WIDTH, w_val);
         write_register(sgd_pkg::REG_FRAME_HEIGHT, h_val);
         w_val  = clamp_int(w_val, sgd_pkg::WIDTH_MIN, sgd_pkg::WIDTH_MAX);
         h_val  = clamp_int(h_val, sgd_pkg::HEIGHT_MIN, sgd_pkg::HEIGHT_MAX);
         frames = $urandom_range(1, 3);
         for (n = 0; n < frames && live_items < RANDOM_ITEMS; n++) begin
            area = w_val * h_val;
            // broken frame: cut short and restarted by the next register write
            if (n == frames - 1 && $urandom_range(0, 4) == 0) begin
               area = $urandom_range(1, area - 1);
            end
            queue_frame(w_val, h_val, texture_type'($urandom_range(0, 3)),
                        n > 0 && $urandom_range(0, 1) == 1, area);
         end
      end

      // all-ones sizes clamp to the largest frame: nothing comes out in its first row
      write_register(sgd_pkg::REG_FRAME_WIDTH, (1 << sgd_pkg::WIDTH_W) - 1);
      write_register(sgd_pkg::REG_FRAME_HEIGHT, (1 << sgd_pkg::HEIGHT_W) - 1);
      queue_frame(sgd_pkg::MAX_WIDTH, sgd_pkg::MAX_HEIGHT, TEX_NOISE, 1'b0, 60);
      // tallest frame, narrowest width, only its first rows
      write_register(sgd_pkg::REG_FRAME_WIDTH, 0);
      write_register(sgd_pkg::REG_FRAME_HEIGHT, sgd_pkg::MAX_HEIGHT);
      queue_frame(3, sgd_pkg::MAX_HEIGHT, TEX_RAMP, 1'b0, 150);
      // one clean small frame after the large ones
      write_register(sgd_pkg::REG_FRAME_HEIGHT, 3);
      queue_frame(3, 3, TEX_GRAIN, 1'b0, 9);

      settle_block();
      $display("covered %0d transactions, %0d results checked, %0d complete frames",
               accepted_count, result_count, frame_count);
      $display("%0d register writes, small random frames plus clamped largest sizes",
               csr_writes);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
